// ===== rtl/core/id3v2_tag_frame_parser_top_macros.svh =====
// assertion helpers used by the parser file id3_parse
// they expect clk and rst_n in the scope of the module that uses them
`ifndef ID3V2_TAG_FRAME_PARSER_TOP_MACROS_SVH
`define ID3V2_TAG_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ID3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define ID3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/id3_pkg.sv =====
`timescale 1ns / 1ps
package id3_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_FIELD   = 2'd1;
    localparam logic [1:0] KIND_NO_TAG  = 2'd2;
    localparam logic [1:0] KIND_TAG_END = 2'd3;

    // parser phases
    localparam logic [1:0] PH_HEADER    = 2'd0;
    localparam logic [1:0] PH_FRAME_HDR = 2'd1;
    localparam logic [1:0] PH_PAYLOAD   = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    localparam int HDR_LEN = 10;
    localparam int SEC_W   = 4;

    // frame identifiers
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

    // frame kinds, zero is skip
    localparam logic [2:0] FK_SKIP  = 3'd0;
    localparam logic [2:0] FK_TIT2  = 3'd1;
    localparam logic [2:0] FK_TPE1  = 3'd2;
    localparam logic [2:0] FK_TALB  = 3'd3;
    localparam logic [2:0] FK_TYER  = 3'd4;
    localparam logic [2:0] FK_TCON  = 3'd5;
    localparam logic [2:0] FK_COMM  = 3'd6;

    // configuration port
    localparam int          PADDR_W             = 3;
    localparam logic        REG_MAX_FIELD_CHARS = 1'b0;
    localparam logic [7:0]  MAX_CHARS_RESET     = 8'd31;

    localparam logic [32:0] CONSUMED_MAX = {33{1'b1}};
    localparam logic [7:0]  SYNCHSAFE_MASK = 8'h7F;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [2:0]  field_type;
        logic [7:0]  char_value;
        logic        has_char;
        logic        field_done;
        logic [7:0]  major_ver;
        logic [7:0]  minor_ver;
        logic [27:0] tag_size;
    } id3_res_t;

    function automatic logic [2:0] classify(input logic [31:0] id);
        logic [2:0] fk;
        case (id)
            ID_TIT2: fk = FK_TIT2;
            ID_TPE1: fk = FK_TPE1;
            ID_TALB: fk = FK_TALB;
            ID_TYER: fk = FK_TYER;
            ID_TCON: fk = FK_TCON;
            ID_COMM: fk = FK_COMM;
            default: fk = FK_SKIP;
        endcase
        return fk;
    endfunction

endpackage

// ===== rtl/core/id3_ifs.sv =====
`timescale 1ns / 1ps
interface id3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface id3_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  field_type;
    logic [7:0]  char_value;
    logic        has_char;
    logic        field_done;
    logic [7:0]  major_ver;
    logic [7:0]  minor_ver;
    logic [27:0] tag_size;

    modport source (
        output valid, output kind, output field_type, output char_value,
        output has_char, output field_done, output major_ver,
        output minor_ver, output tag_size, input ready
    );
    modport sink (
        input valid, input kind, input field_type, input char_value,
        input has_char, input field_done, input major_ver,
        input minor_ver, input tag_size, output ready
    );
endinterface

// ===== rtl/core/id3v2_tag_frame_parser_top.sv =====
`timescale 1ns / 1ps
// id3v2 tag and text frame parser
// in_ch: one file byte per item, file_start high on the first byte of a file
// out_ch: zero or one result per input item - header, field byte, no-tag
//   error or tag end, with version and tag size on the header result
// apb port: register 0 at address 0 is max_field_chars (reset 31), pready
//   always high; write only while the block is idle
// a result is registered and appears on out_ch in the cycle after the byte that causes it
// throughput: one byte per cycle while out_ch is not stalled, set by the
//   single parse step between the parser state registers and the result register
// the parser takes a new byte whenever the result register is empty or is
//   being read in the same cycle, so a stalled receiver holds at most one
//   result and pushes back on in_ch only while that result waits
// reset: parser waits for a header, result register empty, limit back to 31
// a byte with file_start set restarts parsing whatever the previous state
module id3v2_tag_frame_parser_top
    import id3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    id3_in_if.sink             in_ch,
    id3_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] max_chars;
    logic       in_fire;
    id3_res_t   res;

    // output register, valid bit reset, payload plain
    logic       out_valid_reg;
    id3_res_t   out_data_reg;

    id3_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_chars (max_chars)
    );

    // byte taken when the result slot is free or draining this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    id3_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .data_byte  (in_ch.data_byte),
        .file_start (in_ch.file_start),
        .max_chars  (max_chars),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= res.valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_data_reg.kind;
    assign out_ch.field_type = out_data_reg.field_type;
    assign out_ch.char_value = out_data_reg.char_value;
    assign out_ch.has_char   = out_data_reg.has_char;
    assign out_ch.field_done = out_data_reg.field_done;
    assign out_ch.major_ver  = out_data_reg.major_ver;
    assign out_ch.minor_ver  = out_data_reg.minor_ver;
    assign out_ch.tag_size   = out_data_reg.tag_size;

endmodule

// ===== rtl/core/id3_cfg.sv =====
`timescale 1ns / 1ps
module id3_cfg
    import id3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         max_chars
);

    logic [7:0] max_chars_reg;
    logic [7:0] max_chars_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        max_chars_next = max_chars_reg;
        if (wr_en && paddr[2] == REG_MAX_FIELD_CHARS)
        begin
            max_chars_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= MAX_CHARS_RESET;
        end
        else
        begin
            max_chars_reg <= max_chars_next;
        end
    end

    // word-aligned decode, low address bits ignored
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_FIELD_CHARS)
        begin
            prdata = {24'd0, max_chars_reg};
        end
    end

    assign max_chars = max_chars_reg;

endmodule

// ===== rtl/core/id3_parse.sv =====
`timescale 1ns / 1ps
`include "id3v2_tag_frame_parser_top_macros.svh"
module id3_parse
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    input  logic [7:0] max_chars,
    output id3_res_t   res
);

    logic [1:0]       phase_reg,    phase_next;
    logic [SEC_W-1:0] sec_reg,      sec_next;
    logic [27:0]      total_reg,    total_next;
    logic [32:0]      consumed_reg, consumed_next;
    logic [31:0]      flen_reg,     flen_next;
    logic [31:0]      pleft_reg,    pleft_next;
    logic [2:0]       fkind_reg,    fkind_next;
    logic [7:0]       chars_reg,    chars_next;
    logic             ended_reg,    ended_next;
    logic [23:0]      id_reg,       id_next;
    logic [7:0]       hdr_reg [HDR_LEN];

    // state as seen by this item, a file start wipes it
    logic [1:0]       ph;
    logic [SEC_W-1:0] sec;
    logic [27:0]      total;
    logic [32:0]      consumed;
    logic [31:0]      flen;
    logic [31:0]      pleft;
    logic [2:0]       fkind;
    logic [7:0]       chars;
    logic             ended;
    logic [23:0]      id;

    logic [33:0] sum;
    logic [31:0] pleft_dec;
    logic        first, last, emit;

    always_comb
    begin
        ph       = file_start ? PH_HEADER : phase_reg;
        sec      = file_start ? '0 : sec_reg;
        total    = file_start ? '0 : total_reg;
        consumed = file_start ? '0 : consumed_reg;
        flen     = file_start ? '0 : flen_reg;
        pleft    = file_start ? '0 : pleft_reg;
        fkind    = file_start ? FK_SKIP : fkind_reg;
        chars    = file_start ? '0 : chars_reg;
        ended    = file_start ? 1'b0 : ended_reg;
        id       = file_start ? '0 : id_reg;
    end

    assign sum       = {1'b0, consumed} + {2'b00, flen} + 34'd10;
    assign first     = (pleft == flen);
    assign pleft_dec = pleft - {31'd0, (pleft != 32'd0)};
    assign last      = (pleft_dec == 32'd0);

    always_comb
    begin
        phase_next    = ph;
        sec_next      = sec;
        total_next    = total;
        consumed_next = consumed;
        flen_next     = flen;
        pleft_next    = pleft;
        fkind_next    = fkind;
        chars_next    = chars;
        ended_next    = ended;
        id_next       = id;
        emit          = 1'b0;
        res           = '0;

        unique case (ph)
            PH_HEADER:
            begin
                if (sec != SEC_W'(HDR_LEN - 1))
                begin
                    sec_next = sec + 1'b1;
                end
                else
                begin
                    sec_next = '0;
                    res.valid = 1'b1;
                    if (hdr_reg[0] != "I" || hdr_reg[1] != "D" || hdr_reg[2] != "3")
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_NO_TAG;
                    end
                    else
                    begin
                        total_next = {hdr_reg[6][6:0], hdr_reg[7][6:0],
                                      hdr_reg[8][6:0], data_byte[6:0]};
                        phase_next    = PH_FRAME_HDR;
                        res.kind      = KIND_HEADER;
                        res.major_ver = hdr_reg[3];
                        res.minor_ver = hdr_reg[4];
                        res.tag_size  = total_next;
                    end
                end
            end
            PH_FRAME_HDR:
            begin
                sec_next = sec + 1'b1;
                if (sec == 4'd0)
                begin
                    if (consumed >= {5'd0, total} || data_byte == 8'd0)
                    begin
                        phase_next = PH_DONE;
                        sec_next   = sec;
                        res.valid  = 1'b1;
                        res.kind   = KIND_TAG_END;
                    end
                    else
                    begin
                        id_next = {16'd0, data_byte};
                    end
                end
                else if (sec < 4'd3)
                begin
                    id_next = {id[15:0], data_byte};
                end
                else if (sec == 4'd3)
                begin
                    fkind_next = classify({id, data_byte});
                    flen_next  = '0;
                end
                else if (sec < 4'd8)
                begin
                    flen_next = {flen[23:0], data_byte};
                end
                else if (sec >= 4'd9)
                begin
                    consumed_next = sum[33] ? CONSUMED_MAX : sum[32:0];
                    pleft_next    = flen;
                    chars_next    = '0;
                    ended_next    = 1'b0;
                    sec_next      = '0;
                    phase_next    = (flen != 32'd0) ? PH_PAYLOAD : PH_FRAME_HDR;
                end
            end
            PH_PAYLOAD:
            begin
                pleft_next = pleft_dec;
                if (last)
                begin
                    phase_next = PH_FRAME_HDR;
                end
                if (fkind != FK_SKIP)
                begin
                    // encoding byte dropped, text runs to nul or the limit
                    if (!first && !ended)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            ended_next = 1'b1;
                        end
                        else if (chars < max_chars)
                        begin
                            emit       = 1'b1;
                            chars_next = chars + 1'b1;
                        end
                    end
                    if (emit || last)
                    begin
                        res.valid      = 1'b1;
                        res.kind       = KIND_FIELD;
                        res.field_type = fkind - 1'b1;
                        res.char_value = emit ? data_byte : 8'd0;
                        res.has_char   = emit;
                        res.field_done = last;
                    end
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            sec_reg      <= '0;
            total_reg    <= '0;
            consumed_reg <= '0;
            flen_reg     <= '0;
            pleft_reg    <= '0;
            fkind_reg    <= FK_SKIP;
            chars_reg    <= '0;
            ended_reg    <= 1'b0;
            id_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            sec_reg      <= sec_next;
            total_reg    <= total_next;
            consumed_reg <= consumed_next;
            flen_reg     <= flen_next;
            pleft_reg    <= pleft_next;
            fkind_reg    <= fkind_next;
            chars_reg    <= chars_next;
            ended_reg    <= ended_next;
            id_reg       <= id_next;
        end
    end

    // header bytes, written once per file before they are read
    always_ff @(posedge clk)
    begin
        if (fire && ph == PH_HEADER)
        begin
            hdr_reg[sec] <= data_byte;
        end
    end

    `ID3_ASSERT_NOW(a_char_is_field, res.valid && res.has_char, res.kind == KIND_FIELD,
        "character outside a field result")
    `ID3_ASSERT_NOW(a_payload_left, phase_reg == PH_PAYLOAD, pleft_reg != 32'd0,
        "payload phase with nothing left")
    `ID3_ASSERT_NOW(a_sec_range, phase_reg == PH_FRAME_HDR || phase_reg == PH_HEADER,
        sec_reg <= SEC_W'(HDR_LEN - 1), "section index out of range")
    `ID3_ASSERT_NEXT(a_done_sticks, fire && !file_start && phase_reg == PH_DONE,
        phase_reg == PH_DONE, "parser left done without a file start")

endmodule
